>>> hw/rtl/slot_record_table_core_macros.svh
// Assertion macros for the slot record table.
// Expects clk and rst_n in the scope where they are used.
`ifndef SLOT_RECORD_TABLE_CORE_MACROS_SVH
`define SLOT_RECORD_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define SRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot record table: assertion failed");

// next-cycle implication
`define SRT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot record table: assertion failed");

`endif

>>> hw/rtl/srt_pkg.sv
// Shared constants, command codes and types of the slot record table.
// No dependencies.
`default_nettype none

package srt_pkg;

  localparam int SLOTS   = 16;
  localparam int ID_BITS = 16;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);

  // fixed field widths of the ports
  localparam int CMD_W   = 3;
  localparam int KEY_W   = 16;
  localparam int SLOT_W  = 4;
  localparam int ENTRY_W = 16;
  localparam int COUNT_W = 5;
  localparam int CFG_W   = 16;

  localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT_OCC = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COUNT_REM = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SORT_ASC  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SORT_DESC = 3'd6;

  typedef struct packed {
    logic               ok;
    logic [SLOT_W-1:0]  slot_index;
    logic [ENTRY_W-1:0] entry_id;
    logic [COUNT_W-1:0] count;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ID_BITS-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/srt_in_if.sv
// Command channel of the slot record table: valid/ready plus command and key.
// Depends on srt_pkg.
`default_nettype none

interface srt_in_if import srt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key_id;

  modport source (output valid, output cmd, output key_id, input ready);
  modport sink   (input valid, input cmd, input key_id, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/srt_out_if.sv
// Result channel of the slot record table: valid/ready plus result fields.
// Depends on srt_pkg.
`default_nettype none

interface srt_out_if import srt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               ok;
  logic [SLOT_W-1:0]  slot_index;
  logic [ENTRY_W-1:0] entry_id;
  logic [COUNT_W-1:0] count;

  modport source (output valid, output ok, output slot_index, output entry_id,
                  output count, input ready);
  modport sink   (input valid, input ok, input slot_index, input entry_id,
                  input count, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/srt_id_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module srt_id_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hw/rtl/srt_engine.sv
// Command sequencer: slot status bits, id counter, scan and sort over the id RAM.
// Depends on srt_pkg, srt_in_if and the assertion macros header.
`default_nettype none
`include "slot_record_table_core_macros.svh"

module srt_engine import srt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  srt_in_if.sink                  in_ch,
  input  wire logic               cfg_we,
  input  wire logic [CFG_W-1:0]   cfg_wdata,
  output ram_req_t                ram_req,
  input  wire logic [ID_BITS-1:0] rd_data,
  output res_t                    res,
  output logic                    res_valid,
  input  wire logic               res_ready
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_SCAN      = 4'd1;
  localparam logic [3:0] ST_CHECK     = 4'd2;
  localparam logic [3:0] ST_SORT_I    = 4'd3;
  localparam logic [3:0] ST_SORT_ILD  = 4'd4;
  localparam logic [3:0] ST_SORT_J    = 4'd5;
  localparam logic [3:0] ST_SORT_JCMP = 4'd6;
  localparam logic [3:0] ST_SORT_IWB  = 4'd7;
  localparam logic [3:0] ST_DONE      = 4'd8;

  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(SLOTS - 1);
  localparam logic [IDX_W-1:0] I_LAST     = IDX_W'(SLOTS - 2);
  localparam logic [IDX_W-1:0] IDX_ONE    = IDX_W'(1);

  logic [3:0]         state_r, state_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   jdx_r, jdx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ID_BITS-1:0] cur_r, cur_nxt;
  logic [ID_BITS-1:0] ctr_r, ctr_nxt;
  logic [SLOTS-1:0]   occ_r, occ_nxt;
  logic [SLOTS-1:0]   rem_r, rem_nxt;
  res_t               res_r, res_nxt;

  logic               slot_free;
  logic               idx_last;
  logic               jdx_last;
  logic               cnt_bit;
  logic [CNT_W-1:0]   cnt_sum;
  logic [ID_BITS-1:0] ctr_inc;
  logic [ID_BITS-1:0] key_id_w;
  logic               swap;
  logic               ins_hit;

  assign slot_free = !occ_r[idx_r] && !rem_r[idx_r];
  assign idx_last  = (idx_r == IDX_LAST);
  assign jdx_last  = (jdx_r == IDX_LAST);
  assign cnt_bit   = (cmd_r == CMD_COUNT_OCC) ? occ_r[idx_r] : rem_r[idx_r];
  assign cnt_sum   = cnt_r + CNT_W'(cnt_bit);
  assign ctr_inc   = ctr_r + ID_BITS'(1);
  assign key_id_w  = ID_BITS'(key_r);
  assign swap      = (cmd_r == CMD_SORT_DESC) ? (cur_r < rd_data) : (cur_r > rd_data);
  assign ins_hit   = (state_r == ST_SCAN) && (cmd_r == CMD_INSERT) && slot_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign res_valid   = (state_r == ST_DONE);
  assign res         = res_r;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    key_nxt   = key_r;
    idx_nxt   = idx_r;
    jdx_nxt   = jdx_r;
    cnt_nxt   = cnt_r;
    cur_nxt   = cur_r;
    ctr_nxt   = ctr_r;
    occ_nxt   = occ_r;
    rem_nxt   = rem_r;
    res_nxt   = res_r;
    ram_req.we    = 1'b0;
    ram_req.waddr = idx_r;
    ram_req.wdata = cur_r;
    ram_req.raddr = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt = in_ch.cmd;
          key_nxt = in_ch.key_id;
          idx_nxt = '0;
          cnt_nxt = '0;
          res_nxt = '0;
          unique case (in_ch.cmd)
            CMD_INSERT, CMD_REMOVE, CMD_FIND,
            CMD_COUNT_OCC, CMD_COUNT_REM: state_nxt = ST_SCAN;
            CMD_SORT_ASC, CMD_SORT_DESC:  state_nxt = ST_SORT_I;
            default:                      state_nxt = ST_DONE;
          endcase
        end
      end

      ST_SCAN: begin
        unique case (cmd_r)
          CMD_INSERT: begin
            if (slot_free) begin
              ctr_nxt        = ctr_inc;
              ram_req.we     = 1'b1;
              ram_req.wdata  = ctr_inc;
              occ_nxt[idx_r] = 1'b1;
              res_nxt.ok         = 1'b1;
              res_nxt.slot_index = SLOT_W'(idx_r);
              res_nxt.entry_id   = ENTRY_W'(ctr_inc);
              state_nxt = ST_DONE;
            end else if (idx_last) begin
              state_nxt = ST_DONE;
            end else begin
              idx_nxt = idx_r + IDX_ONE;
            end
          end
          CMD_REMOVE, CMD_FIND: begin
            // only occupied slots are compared; the id comes back next cycle
            if (occ_r[idx_r]) begin
              state_nxt = ST_CHECK;
            end else if (idx_last) begin
              state_nxt = ST_DONE;
            end else begin
              idx_nxt = idx_r + IDX_ONE;
            end
          end
          CMD_COUNT_OCC, CMD_COUNT_REM: begin
            if (idx_last) begin
              res_nxt.ok    = 1'b1;
              res_nxt.count = COUNT_W'(cnt_sum);
              state_nxt     = ST_DONE;
            end else begin
              cnt_nxt = cnt_sum;
              idx_nxt = idx_r + IDX_ONE;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end

      ST_CHECK: begin
        if (rd_data == key_id_w) begin
          if (cmd_r == CMD_REMOVE) begin
            occ_nxt[idx_r] = 1'b0;
            rem_nxt[idx_r] = 1'b1;
          end
          res_nxt.ok         = 1'b1;
          res_nxt.slot_index = SLOT_W'(idx_r);
          res_nxt.entry_id   = ENTRY_W'(key_id_w);
          state_nxt = ST_DONE;
        end else if (idx_last) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = idx_r + IDX_ONE;
          state_nxt = ST_SCAN;
        end
      end

      // outer pass: slot i held in cur_r while j sweeps the rest
      ST_SORT_I: begin
        jdx_nxt = idx_r + IDX_ONE;
        if (occ_r[idx_r]) begin
          state_nxt = ST_SORT_ILD;
        end else if (idx_r == I_LAST) begin
          res_nxt.ok = 1'b1;
          state_nxt  = ST_DONE;
        end else begin
          idx_nxt = idx_r + IDX_ONE;
        end
      end

      ST_SORT_ILD: begin
        cur_nxt   = rd_data;
        state_nxt = ST_SORT_J;
      end

      ST_SORT_J: begin
        ram_req.raddr = jdx_r;
        if (occ_r[jdx_r]) begin
          state_nxt = ST_SORT_JCMP;
        end else if (jdx_last) begin
          state_nxt = ST_SORT_IWB;
        end else begin
          jdx_nxt = jdx_r + IDX_ONE;
        end
      end

      ST_SORT_JCMP: begin
        if (swap) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = jdx_r;
          cur_nxt       = rd_data;
        end
        if (jdx_last) begin
          state_nxt = ST_SORT_IWB;
        end else begin
          jdx_nxt   = jdx_r + IDX_ONE;
          state_nxt = ST_SORT_J;
        end
      end

      ST_SORT_IWB: begin
        ram_req.we = 1'b1;
        if (idx_r == I_LAST) begin
          res_nxt.ok = 1'b1;
          state_nxt  = ST_DONE;
        end else begin
          idx_nxt   = idx_r + IDX_ONE;
          state_nxt = ST_SORT_I;
        end
      end

      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // written only while idle by user, so never collides with insert; unenforced
    if (cfg_we) begin
      ctr_nxt = ID_BITS'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ctr_r   <= '0;
      occ_r   <= '0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ctr_r   <= ctr_nxt;
      occ_r   <= occ_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    key_r <= key_nxt;
    idx_r <= idx_nxt;
    jdx_r <= jdx_nxt;
    cnt_r <= cnt_nxt;
    cur_r <= cur_nxt;
    res_r <= res_nxt;
  end

  `SRT_ASSERT_NOW(a_status_excl, 1'b1, (occ_r & rem_r) == '0)
  `SRT_ASSERT_NOW(a_no_wr_idle, (state_r == ST_IDLE) || (state_r == ST_DONE), !ram_req.we)
  `SRT_ASSERT_NXT(a_insert_occ, ins_hit, occ_r[$past(idx_r)] && (state_r == ST_DONE))

endmodule

`default_nettype wire

>>> hw/rtl/slot_record_table_core.sv
// Slot record table top level: sequencer, id RAM and result register.
// Depends on srt_pkg, srt_in_if, srt_out_if, srt_id_ram and srt_engine.
//
//  channel | direction | handshake     | payload
//  in_ch   | in        | valid/ready   | cmd, key_id
//  out_ch  | out       | valid/ready   | ok, slot_index, entry_id, count
//  cfg     | in        | cfg_we only   | cfg_wdata (id counter start)
//
// One item at a time. Insert checks one slot per cycle for the first free one.
// Find and remove step through the slots in the scan state and visit each
// occupied slot again in the check state for the RAM read. Counts scan every
// slot. Sort runs a nested pass over the id RAM read port: each occupied outer
// slot is loaded (SORT_I, SORT_ILD), compared with each occupied partner
// (SORT_J, SORT_JCMP) and written back (SORT_IWB). The result register lets the
// next item in while a result waits; a full register holds the sequencer in its
// final state. Reset is synchronous and clears all slots to free at once; the
// counter restarts at zero.
`default_nettype none

module slot_record_table_core import srt_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  srt_in_if.sink                in_ch,
  srt_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  ram_req_t           ram_req;
  logic [ID_BITS-1:0] rd_data;
  res_t               res;
  logic               res_valid;
  logic               res_ready;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  srt_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ram_req   (ram_req),
    .rd_data   (rd_data),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  srt_id_ram #(
    .DEPTH (SLOTS),
    .WIDTH (ID_BITS)
  ) u_id_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ok         = out_res_r.ok;
  assign out_ch.slot_index = out_res_r.slot_index;
  assign out_ch.entry_id   = out_res_r.entry_id;
  assign out_ch.count      = out_res_r.count;

endmodule

`default_nettype wire

>>> sim/srt_table_monitor.sv
// Watches the command, result and configuration ports of the slot record table,
// keeps its own copy of the table and checks each result against it.
// Depends on srt_pkg, srt_in_if and srt_out_if.
module srt_table_monitor import srt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  srt_in_if                in_ch,
  srt_out_if               out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               outstanding,
  output int               fail_count
);

  typedef enum logic [1:0] {
    SLOT_FREE = 2'd0,
    SLOT_OCC  = 2'd1,
    SLOT_REM  = 2'd2
  } slot_state_e;

  localparam int NO_SLOT = -1;

  logic [ID_BITS-1:0] slot_id [SLOTS];
  slot_state_e        slot_st [SLOTS];
  logic [ID_BITS-1:0] last_id;
  res_t               expected_res_q [$];
  res_t               got, want;
  int                 errors = 0;

  assign fail_count = errors;

  task automatic flag(input string msg);
    $display("srt_table_monitor: %s", msg);
    errors++;
  endtask

  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_id[i] = '0;
      slot_st[i] = SLOT_FREE;
    end
    last_id = '0;
  endfunction

  function automatic int live_slot(input logic [ID_BITS-1:0] key);
    for (int i = 0; i < SLOTS; i++)
      if (slot_st[i] == SLOT_OCC && slot_id[i] == key) return i;
    return NO_SLOT;
  endfunction

  function automatic int tally(input slot_state_e st);
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++)
      if (slot_st[i] == st) n++;
    return n;
  endfunction

  // exchange sort; only pairs where both slots are live take part
  function automatic void order_ids(input bit descending);
    logic [ID_BITS-1:0] t;
    bit                 swap;
    for (int i = 0; i < SLOTS - 1; i++)
      for (int j = i + 1; j < SLOTS; j++)
        if (slot_st[i] == SLOT_OCC && slot_st[j] == SLOT_OCC) begin
          swap = descending ? (slot_id[i] < slot_id[j]) : (slot_id[i] > slot_id[j]);
          if (swap) begin
            t          = slot_id[i];
            slot_id[i] = slot_id[j];
            slot_id[j] = t;
          end
        end
  endfunction

  function automatic res_t table_result(input logic [CMD_W-1:0] cmd,
                                        input logic [KEY_W-1:0] key);
    res_t r;
    int   hit;
    int   n;
    r = '0;
    case (cmd)
      CMD_INSERT: begin
        hit = NO_SLOT;
        for (int i = 0; i < SLOTS; i++)
          if (hit == NO_SLOT && slot_st[i] == SLOT_FREE) hit = i;
        // full table: counter left alone
        if (hit != NO_SLOT) begin
          last_id      = last_id + 1'b1;
          slot_id[hit] = last_id;
          slot_st[hit] = SLOT_OCC;
          r.ok         = 1'b1;
          r.slot_index = hit[SLOT_W-1:0];
          r.entry_id   = last_id;
        end
      end
      CMD_REMOVE, CMD_FIND: begin
        hit = live_slot(key);
        if (hit != NO_SLOT) begin
          if (cmd == CMD_REMOVE) slot_st[hit] = SLOT_REM;
          r.ok         = 1'b1;
          r.slot_index = hit[SLOT_W-1:0];
          r.entry_id   = key;
        end
      end
      CMD_COUNT_OCC: begin
        n       = tally(SLOT_OCC);
        r.ok    = 1'b1;
        r.count = n[COUNT_W-1:0];
      end
      CMD_COUNT_REM: begin
        n       = tally(SLOT_REM);
        r.ok    = 1'b1;
        r.count = n[COUNT_W-1:0];
      end
      CMD_SORT_ASC, CMD_SORT_DESC: begin
        order_ids(cmd == CMD_SORT_DESC);
        r.ok = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_table();
      expected_res_q.delete();
    end else begin
      if (cfg_we) last_id = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        got.ok         = out_ch.ok;
        got.slot_index = out_ch.slot_index;
        got.entry_id   = out_ch.entry_id;
        got.count      = out_ch.count;
        if (expected_res_q.size() == 0) begin
          flag($sformatf("result with none expected: ok=%0d slot=%0d id=%0d count=%0d",
                         got.ok, got.slot_index, got.entry_id, got.count));
        end else begin
          want = expected_res_q.pop_front();
          if (got.ok !== want.ok)
            flag($sformatf("ok: got %0d, expected %0d", got.ok, want.ok));
          if (got.slot_index !== want.slot_index)
            flag($sformatf("slot_index: got %0d, expected %0d",
                           got.slot_index, want.slot_index));
          if (got.entry_id !== want.entry_id)
            flag($sformatf("entry_id: got %0d, expected %0d", got.entry_id, want.entry_id));
          if (got.count !== want.count)
            flag($sformatf("count: got %0d, expected %0d", got.count, want.count));
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_res_q.push_back(table_result(in_ch.cmd, in_ch.key_id));
    end
    outstanding <= expected_res_q.size();
  end

endmodule

>>> sim/tb_top.sv
// Top of the slot record table testbench: clock, reset, command and config stimulus,
// result back-pressure and the verdict. Depends on srt_pkg, the channel interfaces,
// slot_record_table_core and srt_table_monitor.
module tb_top;
  import srt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYCLES = 300;
  localparam int PHASE_ITEMS = 168;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               outstanding;
  int               fail_count;
  int               idle_cycles;
  bit               gapless;
  logic [15:0]      id_bases [$];

  srt_in_if  in_ch ();
  srt_out_if out_ch ();

  slot_record_table_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  srt_table_monitor table_mon (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, the odd long one, none while gapless
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gapless) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)  return CMD_INSERT;
    if (r < 6)  return CMD_REMOVE;
    if (r < 46) return CMD_FIND;
    if (r < 62) return CMD_COUNT_OCC;
    if (r < 76) return CMD_COUNT_REM;
    if (r < 86) return CMD_SORT_ASC;
    if (r < 96) return CMD_SORT_DESC;
    return CMD_UNUSED;
  endfunction

  // keys mostly near ids handed out since some counter start
  function automatic logic [KEY_W-1:0] pick_key();
    int          r;
    logic [15:0] base;
    r    = $urandom_range(0, 99);
    base = id_bases[$urandom_range(0, id_bases.size() - 1)];
    if (r < 75) return base + 16'($urandom_range(1, 8));
    if (r < 92) return 16'($urandom_range(0, 65535));
    return r[0] ? 16'hFFFF : 16'h0000;
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k);
    int g;
    in_ch.valid  <= 1'b1;
    in_ch.cmd    <= c;
    in_ch.key_id <= k;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    g = pick_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // counter start may only change with the table idle
  task automatic load_start(input logic [CFG_W-1:0] v);
    drain();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    id_bases.push_back(v);
  endtask

  // result side back-pressure
  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    logic [15:0] start_plan [$];
    idle_cycles   = 0;
    gapless       = 1'b0;
    rst_n         = 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.cmd    <= CMD_INSERT;
    in_ch.key_id <= '0;
    id_bases.push_back(16'h0000);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: counts, misses, unused code, a sort with nothing live, then a first insert and its find
    send_item(CMD_COUNT_OCC, 16'hFFFF);
    send_item(CMD_COUNT_REM, 16'h0000);
    send_item(CMD_FIND, 16'h0000);
    send_item(CMD_REMOVE, 16'hFFFF);
    send_item(CMD_UNUSED, 16'hFFFF);
    send_item(CMD_SORT_ASC, 16'h0000);
    send_item(CMD_INSERT, 16'h0000);
    send_item(CMD_FIND, 16'h0001);
    // counter wrap, then a duplicate id of 0
    load_start(16'hFFFE);
    send_item(CMD_INSERT, 16'hFFFF);
    send_item(CMD_INSERT, 16'h0000);
    load_start(16'hFFFF);
    send_item(CMD_INSERT, 16'h0000);
    send_item(CMD_FIND, 16'h0000);
    send_item(CMD_SORT_DESC, 16'h0000);
    send_item(CMD_FIND, 16'hFFFF);
    send_item(CMD_SORT_ASC, 16'hFFFF);
    send_item(CMD_FIND, 16'h0001);
    send_item(CMD_REMOVE, 16'h0000);
    send_item(CMD_FIND, 16'h0000);
    send_item(CMD_REMOVE, 16'h0000);
    // removed slots never match again
    send_item(CMD_REMOVE, 16'h0000);
    send_item(CMD_COUNT_OCC, 16'h0000);
    send_item(CMD_COUNT_REM, 16'h0000);
    send_item(CMD_SORT_DESC, 16'h0000);

    start_plan = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'hFFF8, 16'h8000, 16'h0001};
    repeat (4) start_plan.push_back(16'($urandom_range(0, 65535)));
    for (int p = 0; p < start_plan.size(); p++) begin
      load_start(start_plan[p]);
      gapless = (p % 4 == 2);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_item(pick_cmd(), pick_key());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
